@@ rtl/kta_pkg.sv @@
`default_nettype none

package kta_pkg;

  localparam int FRAC_BITS = 16;

  localparam logic signed [63:0] ONE_Q = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] DT_Q = (64'sd2 * ONE_Q + 64'sd50) / 64'sd100;
  localparam logic signed [63:0] DT2_Q = (DT_Q * DT_Q) >>> FRAC_BITS;
  localparam logic signed [63:0] LIM = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] DMAX = (64'sd1 <<< (63 - FRAC_BITS)) - 64'sd1;

  localparam int ANG_SH = 30 - FRAC_BITS;
  localparam logic [63:0] ANG_RND = 64'd1 << (29 - FRAC_BITS);
  localparam logic [63:0] HALF_PI_Q = (64'd1686629713 + ANG_RND) >> ANG_SH;

  localparam int DIV_BITS = 32 + FRAC_BITS;
  localparam int SQRT_STEPS = 32;
  localparam int CORDIC_STEPS = 24;
  localparam int MUL_STEPS = 4;

  localparam logic [30:0] RST_VN_XY = 31'(64'sd5 * ONE_Q);
  localparam logic [30:0] RST_VN_Z = 31'(ONE_Q);
  localparam logic [30:0] RST_MEAS_NOISE = 31'(64'sd200 * ONE_Q);
  localparam logic [30:0] RST_MUZZLE = 31'(64'sd20 * ONE_Q);
  localparam logic [30:0] RST_GRAVITY = 31'((64'sd98 * ONE_Q + 64'sd5) / 64'sd10);

  localparam logic [2:0] REG_VN_X = 3'd0;
  localparam logic [2:0] REG_VN_Y = 3'd1;
  localparam logic [2:0] REG_VN_Z = 3'd2;
  localparam logic [2:0] REG_MEAS_NOISE = 3'd3;
  localparam logic [2:0] REG_MUZZLE = 3'd4;
  localparam logic [2:0] REG_GRAVITY = 3'd5;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_UNREACH = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  typedef enum logic [2:0] {
    OP_MUL    = 3'd0,
    OP_MULRAW = 3'd1,
    OP_DIV    = 3'd2,
    OP_SQRT   = 3'd3,
    OP_ATAN   = 3'd4
  } alu_op_t;

  typedef struct packed {
    logic        start;
    alu_op_t     op;
    logic [63:0] a;
    logic [63:0] b;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] result;
  } alu_resp_t;

  function automatic logic [63:0] mag64(logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  // shift right with truncation toward zero
  function automatic logic signed [63:0] tshr(logic signed [63:0] v, logic [4:0] sh);
    logic [63:0] m;
    m = mag64(v) >> sh;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [64:0] v);
    if (v > 65'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -65'sh0_8000_0000) return 32'sh8000_0000;
    return 32'(v);
  endfunction

  function automatic logic signed [63:0] clampl(logic signed [64:0] v);
    if (v > 65'(LIM)) return LIM;
    if (v < -65'(LIM)) return -LIM;
    return 64'(v);
  endfunction

  function automatic logic [29:0] atan_q30(logic [4:0] i);
    case (i)
      5'd0:  return 30'd843314857;
      5'd1:  return 30'd497837829;
      5'd2:  return 30'd263043836;
      5'd3:  return 30'd133525158;
      5'd4:  return 30'd67021686;
      5'd5:  return 30'd33543515;
      5'd6:  return 30'd16775850;
      5'd7:  return 30'd8388437;
      5'd8:  return 30'd4194282;
      5'd9:  return 30'd2097149;
      5'd10: return 30'd1048575;
      5'd11: return 30'd524288;
      5'd12: return 30'd262144;
      5'd13: return 30'd131072;
      5'd14: return 30'd65536;
      5'd15: return 30'd32768;
      5'd16: return 30'd16384;
      5'd17: return 30'd8192;
      5'd18: return 30'd4096;
      5'd19: return 30'd2048;
      5'd20: return 30'd1024;
      5'd21: return 30'd512;
      5'd22: return 30'd256;
      5'd23: return 30'd128;
      default: return 30'd0;
    endcase
  endfunction

endpackage

`default_nettype wire

@@ rtl/kta_alu.sv @@
`default_nettype none

module kta_alu (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire kta_pkg::alu_req_t   req,
  output kta_pkg::alu_resp_t       resp
);
  import kta_pkg::*;

  typedef enum logic [7:0] {
    A_IDLE = 8'b0000_0001,
    A_MUL  = 8'b0000_0010,
    A_DIV  = 8'b0000_0100,
    A_SQRT = 8'b0000_1000,
    A_NORM = 8'b0001_0000,
    A_ROT  = 8'b0010_0000,
    A_FIN  = 8'b0100_0000,
    A_DONE = 8'b1000_0000
  } alu_state_t;

  alu_state_t state;
  alu_op_t op_r;
  logic [5:0] cnt;
  logic signed [63:0] rx, ry, rz;
  logic [123:0] acc;
  logic [61:0] pp;
  logic [1:0] pp_sh;
  logic neg;
  logic [63:0] res;

  logic signed [63:0] a_s, b_s;
  logic [63:0] ma, mb;
  logic signed [31:0] n32;
  logic [30:0] half_a, half_b;
  logic [61:0] prod;
  logic [123:0] pp_ext;
  logic [63:0] rem_sh, sq_sh, sq_trial;
  logic div_ge, sq_ge;
  logic [63:0] mx, my, mor;
  logic big, tiny;
  logic signed [63:0] xs, ys;
  logic [63:0] mz, mr;
  logic [61:0] mul_mag;
  logic [DIV_BITS-1:0] quo;
  logic [63:0] fin_res;

  always_comb begin
    a_s = $signed(req.a);
    b_s = $signed(req.b);
    ma = mag64(a_s);
    mb = mag64(b_s);
    if (ma > 64'(LIM)) ma = 64'(LIM);
    if (mb > 64'(LIM)) mb = 64'(LIM);
    n32 = sat32(65'(a_s));

    half_a = cnt[1] ? rx[61:31] : rx[30:0];
    half_b = cnt[0] ? ry[61:31] : ry[30:0];
    prod = half_a * half_b;
    case (pp_sh)
      2'd0:    pp_ext = {62'd0, pp};
      2'd1:    pp_ext = {31'd0, pp, 31'd0};
      default: pp_ext = {pp, 62'd0};
    endcase

    rem_sh = {ry[62:0], rx[DIV_BITS-1]};
    div_ge = rem_sh >= 64'(rz);

    sq_sh = {ry[61:0], rx[63:62]};
    sq_trial = {rz[61:0], 2'b01};
    sq_ge = sq_sh >= sq_trial;

    mx = mag64(rx);
    my = mag64(ry);
    mor = mx | my;
    big = |mor[63:40];
    tiny = ~|mor[63:39];
    xs = tshr(rx, cnt[4:0]);
    ys = tshr(ry, cnt[4:0]);

    mz = mag64(rz);
    mr = (mz + ANG_RND) >> ANG_SH;
    if (mr > HALF_PI_Q) mr = HALF_PI_Q;

    mul_mag = (|acc[123:62+FRAC_BITS]) ? 62'(LIM) : acc[61+FRAC_BITS:FRAC_BITS];
    quo = rx[DIV_BITS-1:0];

    case (op_r)
      OP_MUL:    fin_res = neg ? 64'(-$signed({2'b00, mul_mag})) : {2'b00, mul_mag};
      OP_MULRAW: fin_res = acc[63:0];
      OP_DIV: begin
        if (!neg) fin_res = (quo > DIV_BITS'(32'h7FFF_FFFF)) ? 64'h7FFF_FFFF : 64'(quo);
        else fin_res = (quo > DIV_BITS'(33'h0_8000_0000)) ? 64'hFFFF_FFFF_8000_0000
                                                         : 64'(-$signed({1'b0, quo}));
      end
      OP_SQRT:   fin_res = rz;
      OP_ATAN:   fin_res = rz[63] ? 64'(-$signed(mr)) : mr;
      default:   fin_res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
    end else begin
      case (state)
        A_IDLE: begin
          if (req.start) begin
            op_r <= req.op;
            cnt <= '0;
            case (req.op)
              OP_MUL, OP_MULRAW: begin
                rx <= $signed(ma);
                ry <= $signed(mb);
                neg <= a_s[63] ^ b_s[63];
                acc <= '0;
                state <= A_MUL;
              end
              OP_DIV: begin
                if (b_s == 64'sd0) begin
                  res <= '0;
                  state <= A_DONE;
                end else begin
                  rx <= $signed(mag64(64'(n32)) << FRAC_BITS);
                  ry <= '0;
                  rz <= $signed(mag64(b_s));
                  neg <= a_s[63] ^ b_s[63];
                  state <= A_DIV;
                end
              end
              OP_SQRT: begin
                rx <= a_s;
                ry <= '0;
                rz <= '0;
                state <= A_SQRT;
              end
              OP_ATAN: begin
                if (a_s == 64'sd0 && b_s == 64'sd0) begin
                  res <= '0;
                  state <= A_DONE;
                end else begin
                  rx <= a_s;
                  ry <= b_s;
                  state <= A_NORM;
                end
              end
              default: begin
                res <= '0;
                state <= A_DONE;
              end
            endcase
          end
        end
        A_MUL: begin
          // partial product registered, added in the next cycle
          if (cnt < 6'(MUL_STEPS)) begin
            pp <= prod;
            pp_sh <= 2'(cnt[1]) + 2'(cnt[0]);
          end
          if (cnt != 6'd0) acc <= acc + pp_ext;
          cnt <= cnt + 6'd1;
          if (cnt == 6'(MUL_STEPS)) state <= A_FIN;
        end
        A_DIV: begin
          ry <= div_ge ? $signed(rem_sh - 64'(rz)) : $signed(rem_sh);
          rx <= {rx[62:0], div_ge};
          cnt <= cnt + 6'd1;
          if (cnt == 6'(DIV_BITS - 1)) state <= A_FIN;
        end
        A_SQRT: begin
          ry <= sq_ge ? $signed(sq_sh - sq_trial) : $signed(sq_sh);
          rz <= {rz[62:0], sq_ge};
          rx <= {rx[61:0], 2'b00};
          cnt <= cnt + 6'd1;
          if (cnt == 6'(SQRT_STEPS - 1)) state <= A_FIN;
        end
        A_NORM: begin
          if (big) begin
            rx <= tshr(rx, 5'd1);
            ry <= tshr(ry, 5'd1);
          end else if (tiny) begin
            rx <= rx <<< 1;
            ry <= ry <<< 1;
          end else begin
            cnt <= '0;
            rz <= '0;
            state <= A_ROT;
          end
        end
        A_ROT: begin
          if (!ry[63]) begin
            rx <= rx + ys;
            ry <= ry - xs;
            rz <= rz + 64'(atan_q30(cnt[4:0]));
          end else begin
            rx <= rx - ys;
            ry <= ry + xs;
            rz <= rz - 64'(atan_q30(cnt[4:0]));
          end
          cnt <= cnt + 6'd1;
          if (cnt == 6'(CORDIC_STEPS - 1)) state <= A_FIN;
        end
        A_FIN: begin
          res <= fin_res;
          state <= A_DONE;
        end
        A_DONE: begin
          state <= A_IDLE;
        end
        default: state <= A_IDLE;
      endcase
    end
  end

  assign resp.done = (state == A_DONE);
  assign resp.result = res;

endmodule

`default_nettype wire

@@ rtl/kalman_tracker_ballistic_aim.sv @@
// Three-axis constant-velocity Kalman tracker with ballistic aim. Each transfer on the input
// channel is one measured target point (signed Q16.16); the block runs one predict and update
// step per axis, keeps position, velocity and a 2x2 covariance block per axis across items,
// and returns one result: yaw = atan(y/x) and the low ballistic pitch for the configured
// muzzle speed and gravity, both in signed Q2.16 radians, with a status code (0 ok, 1 unreachable,
// 2 filtered x zero). All multiplies, divides, square roots and arctangents run on one shared
// multi-cycle unit (4-step multiplier, bit-serial 48-step divider, 32-step square root,
// normalising 24-step CORDIC) under a sequencer. Per axis the sequencer issues ten multiplies
// and two divides, then rotates the axis slots. When filtered x is zero the aim needs no unit
// operation; otherwise it takes eight multiplies, one root and a CORDIC run for yaw, plus one
// more multiply, a second root and a CORDIC run for pitch when the target is reachable.
// The input is not ready meanwhile; a finished result sits in the output register and the
// next item may be accepted while it waits. Configuration writes are taken at any time but
// are meant for idle periods; indexes beyond the register list are ignored.
`default_nettype none

module kalman_tracker_ballistic_aim (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] meas_x,
  input  wire logic signed [31:0] meas_y,
  input  wire logic signed [31:0] meas_z,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [17:0]      yaw_angle,
  output logic signed [17:0]      pitch_angle,
  output logic [1:0]              aim_status,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [30:0]        cfg_data
);
  import kta_pkg::*;

  typedef enum logic [28:0] {
    S_IDLE  = 29'd1 << 0,
    S_P     = 29'd1 << 1,
    S_A1    = 29'd1 << 2,
    S_A2    = 29'd1 << 3,
    S_B     = 29'd1 << 4,
    S_K0    = 29'd1 << 5,
    S_K1    = 29'd1 << 6,
    S_U0    = 29'd1 << 7,
    S_U1    = 29'd1 << 8,
    S_U2    = 29'd1 << 9,
    S_U3    = 29'd1 << 10,
    S_U4    = 29'd1 << 11,
    S_U5    = 29'd1 << 12,
    S_ROT   = 29'd1 << 13,
    S_CHECK = 29'd1 << 14,
    S_SQ1   = 29'd1 << 15,
    S_SQ2   = 29'd1 << 16,
    S_RNG   = 29'd1 << 17,
    S_V2    = 29'd1 << 18,
    S_SS    = 29'd1 << 19,
    S_GSS   = 29'd1 << 20,
    S_VPZ   = 29'd1 << 21,
    S_V4    = 29'd1 << 22,
    S_GI    = 29'd1 << 23,
    S_YAW   = 29'd1 << 24,
    S_GS    = 29'd1 << 25,
    S_ROOT  = 29'd1 << 26,
    S_PITCH = 29'd1 << 27,
    S_OUT   = 29'd1 << 28
  } seq_state_t;

  seq_state_t state;
  logic issued;
  logic [1:0] axis;

  logic [30:0] vel_noise_x, vel_noise_y, vel_noise_z, meas_noise, muzzle_speed, gravity;

  // the active axis always sits in slot 0; slots rotate after each axis
  logic signed [31:0] pos [3];
  logic signed [31:0] vel [3];
  logic signed [31:0] cv0 [3];
  logic signed [31:0] cv1 [3];
  logic signed [31:0] cv2 [3];
  logic signed [31:0] cv3 [3];
  logic signed [31:0] meas [3];

  logic signed [31:0] p_r, a_r, b_r, c_r, d_r, k0_r, k1_r;
  logic signed [32:0] e_r;
  logic signed [63:0] t_r, u_r, s_r, v2_r;
  logic signed [17:0] yaw_r, pitch_r;
  logic [1:0] status_r;

  alu_req_t req;
  alu_resp_t resp;
  logic signed [63:0] r;
  logic signed [63:0] den;
  logic signed [63:0] dclamp;
  logic [30:0] q_sel;
  logic op_state;

  kta_alu u_alu (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .resp (resp)
  );

  assign r = $signed(resp.result);
  assign den = $signed(64'(a_r) + 64'(meas_noise));
  assign dclamp = (t_r > DMAX) ? DMAX : t_r;
  assign in_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    case (axis)
      2'd0:    q_sel = vel_noise_x;
      2'd1:    q_sel = vel_noise_y;
      default: q_sel = vel_noise_z;
    endcase
  end

  always_comb begin
    req.op = OP_MUL;
    req.a = '0;
    req.b = '0;
    case (state)
      S_P:   begin req.a = DT_Q;  req.b = 64'(vel[0]); end
      S_A1:  begin req.a = DT_Q;  req.b = 64'(cv1[0]) + 64'(cv2[0]); end
      S_A2:  begin req.a = DT2_Q; req.b = 64'(cv3[0]); end
      S_B:   begin req.a = DT_Q;  req.b = 64'(cv3[0]); end
      S_K0:  begin req.op = OP_DIV; req.a = 64'(a_r); req.b = den; end
      S_K1:  begin req.op = OP_DIV; req.a = 64'(c_r); req.b = den; end
      S_U0:  begin req.a = 64'(k0_r); req.b = 64'(e_r); end
      S_U1:  begin req.a = 64'(k1_r); req.b = 64'(e_r); end
      S_U2:  begin req.a = ONE_Q - 64'(k0_r); req.b = 64'(a_r); end
      S_U3:  begin req.a = ONE_Q - 64'(k0_r); req.b = 64'(b_r); end
      S_U4:  begin req.a = 64'(k1_r); req.b = 64'(a_r); end
      S_U5:  begin req.a = 64'(k1_r); req.b = 64'(b_r); end
      S_SQ1: begin req.op = OP_MULRAW; req.a = 64'(pos[0]); req.b = 64'(pos[0]); end
      S_SQ2: begin req.op = OP_MULRAW; req.a = 64'(pos[1]); req.b = 64'(pos[1]); end
      S_RNG: begin req.op = OP_SQRT; req.a = t_r; end
      S_V2:  begin req.a = 64'(muzzle_speed); req.b = 64'(muzzle_speed); end
      S_SS:  begin req.a = s_r; req.b = s_r; end
      S_GSS: begin req.a = 64'(gravity); req.b = t_r; end
      S_VPZ: begin req.a = v2_r; req.b = 64'(pos[2]) <<< 1; end
      S_V4:  begin req.a = v2_r; req.b = v2_r; end
      S_GI:  begin req.a = 64'(gravity); req.b = t_r; end
      S_YAW: begin
        req.op = OP_ATAN;
        if (pos[0] > 32'sd0) begin
          req.a = 64'(pos[0]);
          req.b = 64'(pos[1]);
        end else begin
          req.a = -64'(pos[0]);
          req.b = -64'(pos[1]);
        end
      end
      S_GS:    begin req.a = 64'(gravity); req.b = s_r; end
      S_ROOT:  begin req.op = OP_SQRT; req.a = dclamp <<< FRAC_BITS; end
      S_PITCH: begin req.op = OP_ATAN; req.a = u_r; req.b = v2_r - s_r; end
      default: ;
    endcase
    op_state = !(state inside {S_IDLE, S_ROT, S_CHECK, S_OUT});
    req.start = op_state && !issued;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      issued <= 1'b0;
      axis <= '0;
      out_valid <= 1'b0;
      vel_noise_x <= RST_VN_XY;
      vel_noise_y <= RST_VN_XY;
      vel_noise_z <= RST_VN_Z;
      meas_noise <= RST_MEAS_NOISE;
      muzzle_speed <= RST_MUZZLE;
      gravity <= RST_GRAVITY;
      for (int i = 0; i < 3; i++) begin
        pos[i] <= '0;
        vel[i] <= '0;
        cv0[i] <= 32'(ONE_Q);
        cv1[i] <= 32'(ONE_Q);
        cv2[i] <= 32'(ONE_Q);
        cv3[i] <= 32'(ONE_Q);
      end
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_VN_X:       vel_noise_x <= cfg_data;
          REG_VN_Y:       vel_noise_y <= cfg_data;
          REG_VN_Z:       vel_noise_z <= cfg_data;
          REG_MEAS_NOISE: meas_noise <= cfg_data;
          REG_MUZZLE:     muzzle_speed <= cfg_data;
          REG_GRAVITY:    gravity <= cfg_data;
          default: ;
        endcase
      end

      // in S_OUT the output register is reloaded below
      if (out_valid && out_ready && state != S_OUT) out_valid <= 1'b0;

      if (req.start) issued <= 1'b1;
      if (resp.done) issued <= 1'b0;

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            meas[0] <= meas_x;
            meas[1] <= meas_y;
            meas[2] <= meas_z;
            axis <= '0;
            state <= S_P;
          end
        end
        S_P: if (resp.done) begin
          p_r <= sat32(65'(pos[0]) + 65'(r));
          state <= S_A1;
        end
        S_A1: if (resp.done) begin
          t_r <= 64'(cv0[0]) + r;
          state <= S_A2;
        end
        S_A2: if (resp.done) begin
          a_r <= sat32(65'(t_r) + 65'(r));
          state <= S_B;
        end
        S_B: if (resp.done) begin
          b_r <= sat32(65'(cv1[0]) + 65'(r));
          c_r <= sat32(65'(cv2[0]) + 65'(r));
          d_r <= sat32(65'(cv3[0]) + 65'(q_sel));
          state <= S_K0;
        end
        S_K0: if (resp.done) begin
          k0_r <= r[31:0];
          state <= S_K1;
        end
        S_K1: if (resp.done) begin
          k1_r <= r[31:0];
          e_r <= 33'(meas[0]) - 33'(p_r);
          state <= S_U0;
        end
        S_U0: if (resp.done) begin
          pos[0] <= sat32(65'(p_r) + 65'(r));
          state <= S_U1;
        end
        S_U1: if (resp.done) begin
          vel[0] <= sat32(65'(vel[0]) + 65'(r));
          state <= S_U2;
        end
        S_U2: if (resp.done) begin
          cv0[0] <= sat32(65'(r));
          state <= S_U3;
        end
        S_U3: if (resp.done) begin
          cv1[0] <= sat32(65'(r));
          state <= S_U4;
        end
        S_U4: if (resp.done) begin
          cv2[0] <= sat32(65'(c_r) - 65'(r));
          state <= S_U5;
        end
        S_U5: if (resp.done) begin
          cv3[0] <= sat32(65'(d_r) - 65'(r));
          state <= S_ROT;
        end
        S_ROT: begin
          pos[0] <= pos[1]; pos[1] <= pos[2]; pos[2] <= pos[0];
          vel[0] <= vel[1]; vel[1] <= vel[2]; vel[2] <= vel[0];
          cv0[0] <= cv0[1]; cv0[1] <= cv0[2]; cv0[2] <= cv0[0];
          cv1[0] <= cv1[1]; cv1[1] <= cv1[2]; cv1[2] <= cv1[0];
          cv2[0] <= cv2[1]; cv2[1] <= cv2[2]; cv2[2] <= cv2[0];
          cv3[0] <= cv3[1]; cv3[1] <= cv3[2]; cv3[2] <= cv3[0];
          meas[0] <= meas[1]; meas[1] <= meas[2]; meas[2] <= meas[0];
          axis <= axis + 2'd1;
          state <= (axis == 2'd2) ? S_CHECK : S_P;
        end
        S_CHECK: begin
          if (pos[0] == 32'sd0) begin
            status_r <= ST_ZERO;
            pitch_r <= '0;
            if (pos[1] > 32'sd0) yaw_r <= 18'(HALF_PI_Q);
            else if (pos[1] < 32'sd0) yaw_r <= -18'(HALF_PI_Q);
            else yaw_r <= '0;
            state <= S_OUT;
          end else begin
            state <= S_SQ1;
          end
        end
        S_SQ1: if (resp.done) begin
          t_r <= r;
          state <= S_SQ2;
        end
        S_SQ2: if (resp.done) begin
          t_r <= t_r + r;
          state <= S_RNG;
        end
        S_RNG: if (resp.done) begin
          s_r <= r;
          state <= S_V2;
        end
        S_V2: if (resp.done) begin
          v2_r <= r;
          state <= S_SS;
        end
        S_SS: if (resp.done) begin
          t_r <= r;
          state <= S_GSS;
        end
        S_GSS: if (resp.done) begin
          t_r <= r;
          state <= S_VPZ;
        end
        S_VPZ: if (resp.done) begin
          t_r <= clampl(65'(t_r) + 65'(r));
          state <= S_V4;
        end
        S_V4: if (resp.done) begin
          u_r <= r;
          state <= S_GI;
        end
        S_GI: if (resp.done) begin
          t_r <= clampl(65'(u_r) - 65'(r));
          state <= S_YAW;
        end
        S_YAW: if (resp.done) begin
          yaw_r <= r[17:0];
          if (t_r < 64'sd0) begin
            status_r <= ST_UNREACH;
            pitch_r <= '0;
            state <= S_OUT;
          end else begin
            state <= S_GS;
          end
        end
        S_GS: if (resp.done) begin
          u_r <= r;
          state <= S_ROOT;
        end
        S_ROOT: if (resp.done) begin
          s_r <= r;
          state <= S_PITCH;
        end
        S_PITCH: if (resp.done) begin
          pitch_r <= r[17:0];
          status_r <= ST_OK;
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            yaw_angle <= yaw_r;
            pitch_angle <= pitch_r;
            aim_status <= status_r;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import kta_pkg::*;

  localparam int N_RANDOM = 1500;
  localparam longint MAX_CYCLES = 64'd10000000;
  localparam int DRAIN_CYCLES = 2000;
  localparam int HOLD_CYCLES = 6000;
  localparam logic signed [63:0] HP = $signed(HALF_PI_Q);

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } point_t;

  typedef struct packed {
    logic signed [17:0] yaw;
    logic signed [17:0] pitch;
    logic [1:0]         status;
  } aim_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0, out_ready = 1'b0, cfg_valid = 1'b0;
  logic in_ready, out_valid, cfg_ready;
  logic signed [31:0] meas_x = '0, meas_y = '0, meas_z = '0;
  logic signed [17:0] yaw_angle, pitch_angle;
  logic [1:0] aim_status;
  logic [2:0] cfg_index = '0;
  logic [30:0] cfg_data = '0;

  kalman_tracker_ballistic_aim dut (.*);

  always #10 clk = ~clk;

  // predictor copy of the registers and filter state
  logic [30:0] vn[3];
  logic [30:0] r_meas_noise, r_muzzle, r_gravity;
  logic signed [31:0] trk[6];
  logic signed [31:0] cov[12];

  point_t pending_points[$];
  aim_t expected_aims[$];
  int errors = 0;
  longint cycle = 0;
  bit quiet = 0;
  bit hold_req = 0;
  int hold_left = 0;
  int in_gap = 0, out_gap = 0;
  bit cfg_busy = 0;
  bit in_fire = 0;

  function automatic logic [63:0] mg(logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic signed [63:0] sh_tz(logic signed [63:0] v, int s);
    logic [63:0] m;
    m = mg(v) >> s;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [31:0] s32(logic signed [64:0] v);
    if (v > 65'sd2147483647) return 32'sh7fffffff;
    if (v < -65'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [63:0] cl62(logic signed [64:0] v);
    if (v > 65'(LIM)) return LIM;
    if (v < -65'(LIM)) return -LIM;
    return v[63:0];
  endfunction

  function automatic logic signed [63:0] fx_mul(logic signed [63:0] a, logic signed [63:0] b);
    logic [127:0] p;
    logic [63:0] r;
    p = 128'(mg(cl62(65'(a)))) * 128'(mg(cl62(65'(b))));
    p = p >> FRAC_BITS;
    r = (p > 128'(LIM)) ? 64'(LIM) : p[63:0];
    return ((a < 0) != (b < 0)) ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [31:0] fx_div(logic signed [63:0] n, logic signed [63:0] d);
    logic signed [63:0] q;
    if (d == 0) return 0;
    q = (64'(s32(65'(n))) * ONE_Q) / d;
    return s32(65'(q));
  endfunction

  function automatic logic [63:0] int_root(logic [63:0] n);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else r = r >> 1;
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic signed [63:0] vec_angle(logic signed [63:0] x, logic signed [63:0] y);
    logic signed [63:0] z, xs, ys, r;
    logic [63:0] m;
    z = 0;
    if (x == 0 && y == 0) return 0;
    while ((mg(x) | mg(y)) >= (64'd1 << 40)) begin
      x = sh_tz(x, 1);
      y = sh_tz(y, 1);
    end
    while ((mg(x) | mg(y)) < (64'd1 << 39)) begin
      x = x * 2;
      y = y * 2;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = sh_tz(x, i);
      ys = sh_tz(y, i);
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + atan_q30(5'(i));
      end else begin
        x = x - ys; y = y + xs; z = z - atan_q30(5'(i));
      end
    end
    m = (mg(z) + ANG_RND) >> ANG_SH;
    r = z < 0 ? -$signed(m) : $signed(m);
    if (r > HP) r = HP;
    if (r < -HP) r = -HP;
    return r;
  endfunction

  task automatic track_axis(int k, logic signed [63:0] meas, logic signed [63:0] q);
    logic signed [63:0] p, v, a, b, c, d, s, k0, k1, e;
    p = s32(65'(trk[2*k]) + 65'(fx_mul(DT_Q, trk[2*k+1])));
    v = trk[2*k+1];
    a = s32(65'(cov[4*k]) + 65'(fx_mul(DT_Q, 64'(cov[4*k+1]) + 64'(cov[4*k+2])))
            + 65'(fx_mul(fx_mul(DT_Q, DT_Q), cov[4*k+3])));
    b = s32(65'(cov[4*k+1]) + 65'(fx_mul(DT_Q, cov[4*k+3])));
    c = s32(65'(cov[4*k+2]) + 65'(fx_mul(DT_Q, cov[4*k+3])));
    d = s32(65'(cov[4*k+3]) + 65'(q));
    s = a + 64'(r_meas_noise);
    k0 = fx_div(a, s);
    k1 = fx_div(c, s);
    e = meas - p;
    trk[2*k] = s32(65'(p) + 65'(fx_mul(k0, e)));
    trk[2*k+1] = s32(65'(v) + 65'(fx_mul(k1, e)));
    cov[4*k] = s32(65'(fx_mul(ONE_Q - k0, a)));
    cov[4*k+1] = s32(65'(fx_mul(ONE_Q - k0, b)));
    cov[4*k+2] = s32(65'(c) - 65'(fx_mul(k1, a)));
    cov[4*k+3] = s32(65'(d) - 65'(fx_mul(k1, b)));
  endtask

  task automatic predict_aim(point_t pt);
    aim_t res;
    logic signed [63:0] px, py, pz, g, vq, rng, v2, inner, disc, dc, root, yaw, pitch;
    logic [63:0] sq;
    logic [1:0] st;
    track_axis(0, pt.x, vn[0]);
    track_axis(1, pt.y, vn[1]);
    track_axis(2, pt.z, vn[2]);
    px = trk[0]; py = trk[2]; pz = trk[4];
    pitch = 0;
    st = ST_OK;
    if (px == 0) begin
      st = ST_ZERO;
      yaw = py > 0 ? HP : (py < 0 ? -HP : 64'sd0);
    end else begin
      g = r_gravity;
      vq = r_muzzle;
      sq = 64'(px * px) + 64'(py * py);
      rng = int_root(sq);
      v2 = fx_mul(vq, vq);
      inner = cl62(65'(fx_mul(g, fx_mul(rng, rng))) + 65'(fx_mul(v2, 2 * pz)));
      disc = cl62(65'(fx_mul(v2, v2)) - 65'(fx_mul(g, inner)));
      yaw = px > 0 ? vec_angle(px, py) : vec_angle(-px, -py);
      if (disc < 0) st = ST_UNREACH;
      else begin
        dc = disc > DMAX ? DMAX : disc;
        root = int_root(64'(dc) << FRAC_BITS);
        pitch = vec_angle(fx_mul(g, rng), v2 - root);
      end
    end
    res.yaw = yaw[17:0];
    res.pitch = pitch[17:0];
    res.status = st;
    expected_aims.push_back(res);
  endtask

  // input transfer seen at the rising edge, used by the driver at the next falling edge
  always @(posedge clk) begin
    in_fire <= in_valid && in_ready;
  end

  // driver
  always @(negedge clk) begin
    if (!rst) begin
      if (in_fire) begin
        predict_aim(pending_points.pop_front());
      end
      if (!in_valid || in_fire) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_points.size() > 0 && !cfg_busy &&
                     (quiet || $urandom_range(0, 5) != 0)) begin
          in_valid <= 1'b1;
          meas_x <= pending_points[0].x;
          meas_y <= pending_points[0].y;
          meas_z <= pending_points[0].z;
        end else begin
          in_valid <= 1'b0;
          if (!quiet) in_gap <= $urandom_range(0, 2);
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_aims.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result yaw=%0d pitch=%0d status=%0d",
                                   yaw_angle, pitch_angle, aim_status);
      end else begin
        aim_t ex;
        ex = expected_aims.pop_front();
        if (ex.yaw !== yaw_angle || ex.pitch !== pitch_angle || ex.status !== aim_status) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp yaw=%0d pitch=%0d status=%0d, got %0d %0d %0d",
                     ex.yaw, ex.pitch, ex.status, yaw_angle, pitch_angle, aim_status);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst) out_ready <= 1'b0;
    else if (hold_req || hold_left > 0) begin
      out_ready <= 1'b0;
      if (hold_req) begin
        hold_left <= HOLD_CYCLES;
        hold_req <= 1'b0;
      end else hold_left <= hold_left - 1;
    end else if (out_gap > 0) begin
      out_ready <= 1'b0;
      out_gap <= out_gap - 1;
    end else begin
      out_ready <= 1'b1;
      if (!quiet && $urandom_range(0, 7) == 0) out_gap <= $urandom_range(1, 3);
    end
  end

  always @(posedge clk) begin
    cycle++;
    if (cycle > MAX_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_points.size() > 0 || expected_aims.size() > 0 || in_valid)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [30:0] val);
    cfg_busy = 1'b1;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_VN_X: vn[0] = val;
      REG_VN_Y: vn[1] = val;
      REG_VN_Z: vn[2] = val;
      REG_MEAS_NOISE: r_meas_noise = val;
      REG_MUZZLE: r_muzzle = val;
      REG_GRAVITY: r_gravity = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_busy = 1'b0;
  endtask

  function automatic logic signed [31:0] rnd_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h7fff)) - 32'sh4000;
      default: return ($signed($urandom_range(0, 400 << 16)) - (200 << 16));
    endcase
  endfunction

  // a moving target with random noise on top of a steady track
  task automatic add_track(int n);
    point_t pt;
    logic signed [31:0] bx, by, bz, dx, dy, dz;
    bx = $signed($urandom_range(1 << 16, 60 << 16)) * ($urandom_range(0, 1) ? 1 : -1);
    by = $signed($urandom_range(0, 60 << 16)) - (30 << 16);
    bz = $signed($urandom_range(0, 20 << 16)) - (5 << 16);
    dx = $signed($urandom_range(0, 8000)) - 4000;
    dy = $signed($urandom_range(0, 8000)) - 4000;
    dz = $signed($urandom_range(0, 2000)) - 1000;
    for (int i = 0; i < n; i++) begin
      pt.x = bx + i * dx + $signed($urandom_range(0, 20000)) - 10000;
      pt.y = by + i * dy + $signed($urandom_range(0, 20000)) - 10000;
      pt.z = bz + i * dz + $signed($urandom_range(0, 20000)) - 10000;
      pending_points.push_back(pt);
    end
  endtask

  function automatic point_t mk(logic signed [31:0] x, logic signed [31:0] y,
                                logic signed [31:0] z);
    point_t p;
    p.x = x; p.y = y; p.z = z;
    return p;
  endfunction

  initial begin
    int done_items;
    vn[0] = RST_VN_XY; vn[1] = RST_VN_XY; vn[2] = RST_VN_Z;
    r_meas_noise = RST_MEAS_NOISE; r_muzzle = RST_MUZZLE; r_gravity = RST_GRAVITY;
    for (int i = 0; i < 6; i++) trk[i] = 32'sd0;
    for (int i = 0; i < 12; i++) cov[i] = 32'(ONE_Q);
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: zero point, axis extremes, unreachable and far targets
    pending_points.push_back(mk(0, 0, 0));
    pending_points.push_back(mk(0, 5 << 16, 0));
    pending_points.push_back(mk(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff));
    pending_points.push_back(mk(32'sh80000000, 32'sh80000000, 32'sh80000000));
    pending_points.push_back(mk(32'sh7fffffff, 32'sh80000000, 0));
    pending_points.push_back(mk(-1, 1, -1));
    pending_points.push_back(mk(10 << 16, -(3 << 16), 2 << 16));
    pending_points.push_back(mk(-(10 << 16), 3 << 16, 1000 << 16));
    wait_idle();
    // zero gravity, zero measurement noise so innovation variance can vanish
    write_reg(REG_GRAVITY, 31'd0);
    write_reg(REG_MEAS_NOISE, 31'd0);
    write_reg(REG_VN_X, 31'd0);
    write_reg(REG_VN_Y, 31'h7fffffff);
    write_reg(REG_VN_Z, 31'd0);
    write_reg(3'd6, 31'h1234);
    write_reg(3'd7, 31'h7fffffff);
    pending_points.push_back(mk(20 << 16, 4 << 16, 1 << 16));
    pending_points.push_back(mk(-(20 << 16), 0, -(50 << 16)));
    pending_points.push_back(mk(0, -(4 << 16), 0));
    wait_idle();
    write_reg(REG_GRAVITY, 31'h7fffffff);
    write_reg(REG_MUZZLE, 31'h7fffffff);
    write_reg(REG_MEAS_NOISE, 31'h7fffffff);
    pending_points.push_back(mk(30 << 16, 30 << 16, 0));
    pending_points.push_back(mk(32'sh80000000, 5, 32'sh7fffffff));
    wait_idle();
    write_reg(REG_MUZZLE, 31'd0);
    pending_points.push_back(mk(30 << 16, 30 << 16, 0));
    wait_idle();

    // random phases with varying settings
    done_items = 0;
    for (int ph = 0; done_items < N_RANDOM; ph++) begin
      int n;
      if (ph % 3 == 0) begin
        write_reg(REG_VN_X, 31'($urandom_range(0, 10 << 16)));
        write_reg(REG_VN_Y, 31'($urandom_range(0, 10 << 16)));
        write_reg(REG_VN_Z, 31'(ph % 6 == 0 ? $urandom : $urandom_range(0, 10 << 16)));
        write_reg(REG_MEAS_NOISE,
                  31'(ph % 9 == 0 ? $urandom : $urandom_range(0, 400 << 16)));
        write_reg(REG_MUZZLE, 31'($urandom_range(0, 80 << 16)));
        write_reg(REG_GRAVITY,
                  ph % 5 == 0 ? 31'($urandom_range(0, 3)) : RST_GRAVITY);
      end
      if (done_items > N_RANDOM * 4 / 5) quiet = 1;
      n = $urandom_range(20, 60);
      if ($urandom_range(0, 4) == 0)
        for (int i = 0; i < n; i++)
          pending_points.push_back(mk(rnd_coord(), rnd_coord(), rnd_coord()));
      else add_track(n);
      if (ph == 2) hold_req = 1;
      done_items += n;
      wait_idle();
    end

    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire
